// File: src/mctt_pkg.sv
// ----------------------------------------------------------------------------
// mctt_pkg
// Shared constants, widths and control structs for the square-wave toggler.
// ----------------------------------------------------------------------------
package mctt_pkg;

    // Channel layout
    localparam int CHANNEL_COUNT = 12;
    localparam int FIRST_PIN     = 2;
    localparam int CH_W          = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    // Item field widths
    localparam int KIND_W = 2;
    localparam int PIN_W  = 4;
    localparam int FREQ_W = 16;
    localparam int OUT_W  = 12;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

    // Period arithmetic: 500 Hz in Q10.6 and twice that
    localparam int PER_W       = 15;
    localparam int NUM_W       = 17;
    localparam int FREQ_CLAMP  = 32000;
    localparam int TWICE_CLAMP = 64000;
    localparam int DIV_STEPS   = PER_W;

    // Shared step counter: channel walk or division steps
    localparam int CNT_MAX = (CHANNEL_COUNT > DIV_STEPS) ? CHANNEL_COUNT : DIV_STEPS;
    localparam int CNT_W   = $clog2(CNT_MAX);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic            latch;
        logic            dispatch;
        logic            walk;
        logic [CH_W-1:0] walk_idx;
        logic            div_step;
        logic            write_period;
        logic            load_out;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_tick;
        logic needs_div;
        logic out_free;
    } status_t;

endpackage

// File: src/mctt_if.sv
// ----------------------------------------------------------------------------
// mctt_if
// Valid/ready channels for incoming items and outgoing results.
// ----------------------------------------------------------------------------
interface mctt_in_if;
    logic                        valid;
    logic                        ready;
    logic [mctt_pkg::KIND_W-1:0] kind;
    logic [mctt_pkg::PIN_W-1:0]  pin_number;
    logic [mctt_pkg::FREQ_W-1:0] freq_value;

    modport source (output valid, output kind, output pin_number, output freq_value,
                    input ready);
    modport sink   (input valid, input kind, input pin_number, input freq_value,
                    output ready);
endinterface

interface mctt_out_if;
    logic                       valid;
    logic                       ready;
    logic [mctt_pkg::OUT_W-1:0] pin_levels;
    logic [mctt_pkg::OUT_W-1:0] active_mask;

    modport source (output valid, output pin_levels, output active_mask, input ready);
    modport sink   (input valid, input pin_levels, input active_mask, output ready);
endinterface

// File: src/multi_channel_tone_toggler.sv
// ----------------------------------------------------------------------------
// multi_channel_tone_toggler
// Flow: a tick walks the channels (one channel a cycle), a play runs the
// fifteen-step serial divider; stop, zero-frequency or ignored items skip both.
// Throughput: one item at a time; the next item is taken as soon as its
// result sits in the output register, even if that beat is not yet taken.
// Reset: asynchronous, all channels disabled, phases zero, all levels low.
// ----------------------------------------------------------------------------
module multi_channel_tone_toggler (
    input  logic      clk,
    input  logic      rst_n,
    mctt_in_if.sink   item,
    mctt_out_if.source result
);

    mctt_pkg::cmd_t    cmd;
    mctt_pkg::status_t status;
    logic              ready;

    assign item.ready = ready;

    // Sequencer
    mctt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Channel state and arithmetic
    mctt_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (item.kind),
        .pin_number (item.pin_number),
        .freq_value (item.freq_value),
        .cmd        (cmd),
        .status     (status),
        .result     (result)
    );

endmodule

// File: src/mctt_datapath.sv
// ----------------------------------------------------------------------------
// mctt_datapath
// Channel state, item latch, serial period divider and result register.
// ----------------------------------------------------------------------------
module mctt_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [mctt_pkg::KIND_W-1:0] kind,
    input  logic [mctt_pkg::PIN_W-1:0]  pin_number,
    input  logic [mctt_pkg::FREQ_W-1:0] freq_value,
    input  mctt_pkg::cmd_t     cmd,
    output mctt_pkg::status_t  status,
    mctt_out_if.source         result
);

    localparam int CC = mctt_pkg::CHANNEL_COUNT;

    // Latched item
    logic [mctt_pkg::KIND_W-1:0] kind_reg;
    logic [mctt_pkg::PIN_W-1:0]  pin_reg;
    logic [mctt_pkg::FREQ_W-1:0] freq_reg;

    // Channel state
    logic [mctt_pkg::PER_W-1:0] hp_reg [CC];
    logic [mctt_pkg::PER_W-1:0] ph_reg [CC];
    logic [CC-1:0]              lvl_reg;

    // Divider state
    logic [mctt_pkg::NUM_W-1:0] rem_reg;
    logic [mctt_pkg::PER_W-1:0] num_reg;
    logic [mctt_pkg::PER_W-1:0] quo_reg;
    logic [mctt_pkg::NUM_W-1:0] dvs_reg;

    // Result register
    logic                       out_valid_reg;
    logic [mctt_pkg::OUT_W-1:0] pins_reg;
    logic [mctt_pkg::OUT_W-1:0] mask_reg;

    // Decode
    logic [5:0]                 pin_off;
    logic                       pin_ok;
    logic [mctt_pkg::CH_W-1:0]  chan;
    logic [mctt_pkg::PER_W-1:0] v_clamp;
    logic                       v_zero;
    logic [mctt_pkg::NUM_W-1:0] num_full;
    logic                       is_play;
    logic                       is_stop;
    logic [CC-1:0]              en_bits;

    // Divider step
    logic [mctt_pkg::NUM_W:0]   trial;
    logic                       trial_ge;
    logic [mctt_pkg::NUM_W:0]   trial_sub;

    // Walk step
    logic [mctt_pkg::PER_W-1:0] walk_hp;
    logic [mctt_pkg::PER_W-1:0] walk_ph_inc;
    logic                       walk_on;
    logic                       walk_wrap;

    // Decode the latched item
    always_comb
    begin
        pin_off  = {2'b00, pin_reg} - 6'(mctt_pkg::FIRST_PIN);
        pin_ok   = ({2'b00, pin_reg} >= 6'(mctt_pkg::FIRST_PIN)) && (pin_off < 6'(CC));
        chan     = pin_off[mctt_pkg::CH_W-1:0];
        is_play  = (kind_reg == mctt_pkg::KIND_PLAY);
        is_stop  = (kind_reg == mctt_pkg::KIND_STOP);
        v_clamp  = (freq_reg > 16'(mctt_pkg::FREQ_CLAMP))
                 ? 15'(mctt_pkg::FREQ_CLAMP) : freq_reg[mctt_pkg::PER_W-1:0];
        v_zero   = (v_clamp == '0);
        num_full = 17'(mctt_pkg::TWICE_CLAMP) + {2'b00, v_clamp};
    end

    // One restoring division step
    always_comb
    begin
        trial     = {rem_reg, num_reg[mctt_pkg::PER_W-1]};
        trial_ge  = (trial >= {1'b0, dvs_reg});
        trial_sub = trial - {1'b0, dvs_reg};
    end

    // One channel of the tick walk
    always_comb
    begin
        walk_hp     = hp_reg[cmd.walk_idx];
        walk_ph_inc = ph_reg[cmd.walk_idx] + 15'd1;
        walk_on     = (walk_hp != '0);
        walk_wrap   = (walk_ph_inc >= walk_hp);
    end

    // Enabled channels
    always_comb
    begin
        for (int i = 0; i < CC; i++)
        begin
            en_bits[i] = (hp_reg[i] != '0);
        end
    end

    assign status.is_tick   = (kind_reg == mctt_pkg::KIND_TICK);
    assign status.needs_div = is_play && pin_ok && !v_zero;
    assign status.out_free  = !out_valid_reg || result.ready;

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= kind;
            pin_reg  <= pin_number;
            freq_reg <= freq_value;
        end
    end

    // Divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.dispatch)
        begin
            rem_reg <= {15'd0, num_full[mctt_pkg::NUM_W-1:mctt_pkg::PER_W]};
            num_reg <= num_full[mctt_pkg::PER_W-1:0];
            quo_reg <= '0;
            dvs_reg <= {1'b0, v_clamp, 1'b0};
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[mctt_pkg::NUM_W-1:0]
                                : trial[mctt_pkg::NUM_W-1:0];
            num_reg <= {num_reg[mctt_pkg::PER_W-2:0], 1'b0};
            quo_reg <= {quo_reg[mctt_pkg::PER_W-2:0], trial_ge};
        end
    end

    // Channel state: walk, stop, disable and period write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CC; i++)
            begin
                hp_reg[i] <= '0;
                ph_reg[i] <= '0;
            end
            lvl_reg <= '0;
        end
        else if (cmd.walk)
        begin
            if (walk_on)
            begin
                if (walk_wrap)
                begin
                    ph_reg[cmd.walk_idx]  <= '0;
                    lvl_reg[cmd.walk_idx] <= ~lvl_reg[cmd.walk_idx];
                end
                else
                begin
                    ph_reg[cmd.walk_idx] <= walk_ph_inc;
                end
            end
        end
        else if (cmd.dispatch)
        begin
            // A zero frequency disables and keeps level and phase
            if (is_play && pin_ok && v_zero)
            begin
                hp_reg[chan] <= '0;
            end
            // Stop disables and drives low
            if (is_stop && pin_ok)
            begin
                hp_reg[chan]  <= '0;
                lvl_reg[chan] <= 1'b0;
            end
        end
        else if (cmd.write_period)
        begin
            hp_reg[chan] <= quo_reg;
            ph_reg[chan] <= '0;
        end
    end

    // Result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pins_reg <= mctt_pkg::OUT_W'(lvl_reg);
            mask_reg <= mctt_pkg::OUT_W'(en_bits);
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.pin_levels  = pins_reg;
    assign result.active_mask = mask_reg;

endmodule

// File: src/mctt_ctrl.sv
// ----------------------------------------------------------------------------
// mctt_ctrl
// Sequencer: accepts an item, runs the channel walk or the period division if the item needs one,
// then hands the result beat to the output register.
// ----------------------------------------------------------------------------
module mctt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mctt_pkg::status_t status,
    output mctt_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_WALK     = 6'b000100,
        S_DIV      = 6'b001000,
        S_WRITE    = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    localparam logic [mctt_pkg::CNT_W-1:0] WALK_LAST = mctt_pkg::CNT_W'(mctt_pkg::CHANNEL_COUNT - 1);
    localparam logic [mctt_pkg::CNT_W-1:0] DIV_LAST  = mctt_pkg::CNT_W'(mctt_pkg::DIV_STEPS - 1);

    state_t                     state_reg;
    state_t                     state_next;
    logic [mctt_pkg::CNT_W-1:0] cnt_reg;
    logic [mctt_pkg::CNT_W-1:0] cnt_next;

    // Next state and commands
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        in_ready         = 1'b0;
        cmd              = '0;
        cmd.walk_idx     = cnt_reg[mctt_pkg::CH_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.dispatch = 1'b1;
                cnt_next     = '0;
                if (status.is_tick)
                begin
                    state_next = S_WALK;
                end
                else if (status.needs_div)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == WALK_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write_period = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
